>>> hw/rtl/lpodm_pkg.sv
package lpodm_pkg;

    localparam int WINDOW_COUNTER_BITS_DEF = 32;

    localparam int ELAPSED_BITS    = 48;
    localparam int CFG_BITS        = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int STATUS_BITS     = 2;
    localparam int RATIO_BITS      = 23;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int CONC_BITS       = 29;
    localparam int MS_BITS         = 39;

    localparam int MS_DIV_BITS   = 46;
    localparam int MS_DIVISOR    = 125;
    localparam int CONC_DIV_BITS = 34;
    localparam int CONC_DIVISOR  = 25;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_WINDOW = 2'd1;

    localparam logic [CFG_BITS-1:0] WARMUP_RESET     = 32'd60000000;
    localparam logic [CFG_BITS-1:0] MIN_WINDOW_RESET = 32'd30000000;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_WARMUP  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SHORT   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EXCEED  = 2'd3;

    localparam logic [RATIO_BITS-1:0] RATIO_MAX = 23'd6553600;
    localparam logic [CONC_BITS-1:0]  CONC_MAX  = 29'h1FFFFFFF;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic rnd;
        logic p1;
        logic p2;
        logic p3;
        logic p4;
        logic p5;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic div_last;
        logic ms_busy;
        logic cd_busy;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/lpodm_cdiv.sv
module lpodm_cdiv #(
    parameter int WIDTH   = lpodm_pkg::MS_DIV_BITS,
    parameter int DIVISOR = lpodm_pkg::MS_DIVISOR
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    output logic [WIDTH-1:0] o_quotient,
    output logic             o_busy
);

    localparam int STEPS = WIDTH / 2;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int RW    = $clog2(DIVISOR);
    localparam int TW    = RW + 2;

    localparam logic [TW-1:0] L_D1 = TW'(DIVISOR);
    localparam logic [TW-1:0] L_D2 = TW'(2 * DIVISOR);
    localparam logic [TW-1:0] L_D3 = TW'(3 * DIVISOR);

    logic [WIDTH-1:0] r_work;
    logic [RW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    logic [TW-1:0] w_t;
    logic [TW-1:0] w_diff;
    logic [1:0]    w_digit;
    logic [RW-1:0] n_rem;

    always_comb begin
        w_t = {r_rem, r_work[WIDTH-1 -: 2]};
        if (w_t >= L_D3) begin
            w_digit = 2'd3;
            w_diff  = w_t - L_D3;
        end else if (w_t >= L_D2) begin
            w_digit = 2'd2;
            w_diff  = w_t - L_D2;
        end else if (w_t >= L_D1) begin
            w_digit = 2'd1;
            w_diff  = w_t - L_D1;
        end else begin
            w_digit = 2'd0;
            w_diff  = w_t;
        end
        n_rem = w_diff[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= {r_work[WIDTH-3:0], w_digit};
            r_rem  <= n_rem;
        end
    end

    assign o_quotient = r_work;
    assign o_busy     = r_busy;

endmodule

>>> hw/rtl/lpodm_ctrl.sv
module lpodm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_poll,
    input  lpodm_pkg::t_sts   i_sts,
    output lpodm_pkg::t_cmd   o_cmd,
    output logic              o_stall
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_RND  = 4'd3;
    localparam logic [3:0] S_P1   = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_P3   = 4'd6;
    localparam logic [3:0] S_P4   = 4'd7;
    localparam logic [3:0] S_P5   = 4'd8;
    localparam logic [3:0] S_CD   = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid && i_poll) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.div_init = 1'b1;
                n_state = i_sts.ok ? S_DIV : S_WAIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_P1;
            end
            S_P1: begin
                o_cmd.p1 = 1'b1;
                n_state = S_P2;
            end
            S_P2: begin
                o_cmd.p2 = 1'b1;
                n_state = S_P3;
            end
            S_P3: begin
                o_cmd.p3 = 1'b1;
                n_state = S_P4;
            end
            S_P4: begin
                o_cmd.p4 = 1'b1;
                n_state = S_P5;
            end
            S_P5: begin
                o_cmd.p5 = 1'b1;
                n_state = S_CD;
            end
            S_CD: begin
                if (!i_sts.cd_busy) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_sts.ms_busy && i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

>>> hw/rtl/lpodm_dp.sv
module lpodm_dp #(
    parameter int WINDOW_COUNTER_BITS = lpodm_pkg::WINDOW_COUNTER_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lpodm_pkg::t_cmd                       i_cmd,
    output lpodm_pkg::t_sts                       o_sts,
    input  logic                                  i_pin_level,
    input  logic                                  i_poll,
    input  logic                                  i_stall,
    input  logic                                  i_cfg_we,
    input  logic [lpodm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lpodm_pkg::CFG_BITS-1:0]        i_cfg_data,
    output logic                                  o_valid,
    output logic [lpodm_pkg::STATUS_BITS-1:0]     o_status,
    output logic [lpodm_pkg::RATIO_BITS-1:0]      o_low_ratio,
    output logic [lpodm_pkg::CONC_BITS-1:0]       o_concentration,
    output logic [lpodm_pkg::MS_BITS-1:0]         o_elapsed_ms
);

    localparam int W    = WINDOW_COUNTER_BITS;
    localparam int MW   = W + 7;
    localparam int CMPW = (W > lpodm_pkg::CFG_BITS) ? W : lpodm_pkg::CFG_BITS;
    localparam int EB   = lpodm_pkg::ELAPSED_BITS;
    localparam int RB   = lpodm_pkg::RATIO_BITS;
    localparam int FB   = lpodm_pkg::RATIO_FRAC_BITS;
    localparam int DCW  = $clog2(RB);
    localparam int MSB  = lpodm_pkg::MS_DIV_BITS;
    localparam int CDB  = lpodm_pkg::CONC_DIV_BITS;

    logic [lpodm_pkg::CFG_BITS-1:0] r_warmup;
    logic [lpodm_pkg::CFG_BITS-1:0] r_min_win;

    logic [EB-1:0] r_elapsed;
    logic [W-1:0]  r_win;
    logic [W-1:0]  r_low;
    logic [EB-1:0] n_elapsed;
    logic [W-1:0]  n_win;
    logic [W-1:0]  n_low;

    logic [W-1:0]                      r_win_s;
    logic [W-1:0]                      r_low_s;
    logic [lpodm_pkg::STATUS_BITS-1:0] r_stat;
    logic [lpodm_pkg::STATUS_BITS-1:0] n_stat;

    logic [W-1:0]   r_rem;
    logic [RB-1:0]  r_num;
    logic [DCW-1:0] r_div_cnt;
    logic [MW-1:0]  w_m;
    logic [W:0]     w_t;
    logic           w_ge;
    logic [W:0]     w_sub;
    logic           w_round;

    logic [RB-1:0] r_q;
    logic [45:0]   r_sq;
    logic [29:0]   r_s;
    logic [46:0]   w_sq_rnd;
    logic [52:0]   r_sqq;
    logic [53:0]   r_neg;
    logic [59:0]   r_pos;
    logic [59:0]   w_diff;
    logic [59:0]   w_x;

    logic           w_ms_start;
    logic [MSB-1:0] w_ms_q;
    logic           w_ms_busy;
    logic [CDB-1:0] w_cd_q;
    logic           w_cd_busy;
    logic [lpodm_pkg::CONC_BITS-1:0] w_conc;

    logic                              r_out_valid;
    logic [lpodm_pkg::STATUS_BITS-1:0] r_out_status;
    logic [RB-1:0]                     r_out_ratio;
    logic [lpodm_pkg::CONC_BITS-1:0]   r_out_conc;
    logic [lpodm_pkg::MS_BITS-1:0]     r_out_ms;
    logic                              w_ok;

    always_comb begin
        n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + EB'(1);
        n_win     = (r_win == '1) ? r_win : r_win + W'(1);
        n_low     = r_low;
        if (!i_pin_level) begin
            n_low = (r_low == '1) ? r_low : r_low + W'(1);
        end
        if (n_elapsed < EB'(r_warmup)) begin
            n_stat = lpodm_pkg::ST_WARMUP;
        end else if (n_win == '0 || CMPW'(n_win) < CMPW'(r_min_win)) begin
            n_stat = lpodm_pkg::ST_SHORT;
        end else if (n_low > n_win) begin
            n_stat = lpodm_pkg::ST_EXCEED;
        end else begin
            n_stat = lpodm_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup  <= lpodm_pkg::WARMUP_RESET;
            r_min_win <= lpodm_pkg::MIN_WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpodm_pkg::REG_WARMUP:     r_warmup  <= i_cfg_data;
                lpodm_pkg::REG_MIN_WINDOW: r_min_win <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_win     <= '0;
            r_low     <= '0;
            r_stat    <= lpodm_pkg::ST_OK;
        end else if (i_cmd.accept) begin
            r_elapsed <= n_elapsed;
            if (i_poll) begin
                r_win  <= '0;
                r_low  <= '0;
                r_stat <= n_stat;
            end else begin
                r_win <= n_win;
                r_low <= n_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_poll) begin
            r_win_s <= n_win;
            r_low_s <= n_low;
        end
    end

    // The quotient is known to fit the ratio width, so the division starts from the
    // scaled numerator shifted down by that width and brings in one bit a step.
    assign w_m     = MW'(r_low_s) * MW'(100);
    assign w_t     = {r_rem, r_num[RB-1]};
    assign w_ge    = (w_t >= {1'b0, r_win_s});
    assign w_sub   = w_ge ? (w_t - {1'b0, r_win_s}) : w_t;
    assign w_round = ({r_rem, 1'b0} >= {1'b0, r_win_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= w_m[MW-1:7];
            r_num <= {w_m[6:0], FB'(0)};
        end else if (i_cmd.div_step) begin
            r_rem <= w_sub[W-1:0];
            r_num <= {r_num[RB-2:0], w_ge};
        end
    end

    assign w_sq_rnd = {1'b0, r_sq} + 47'd32768;
    assign w_diff   = (r_pos > 60'(r_neg)) ? (r_pos - 60'(r_neg)) : 60'd0;
    assign w_x      = w_diff + (60'd50 << 24);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd) begin
            r_q <= r_num + RB'(w_round);
        end
        if (i_cmd.p1) begin
            r_sq <= 46'(r_q) * 46'(r_q);
        end
        if (i_cmd.p2) begin
            r_s <= w_sq_rnd[45:16];
        end
        if (i_cmd.p3) begin
            r_sqq <= 53'(r_s) * 53'(r_q);
            r_neg <= (54'(r_s) * 54'd380) << 16;
        end
        if (i_cmd.p4) begin
            r_pos <= 60'(r_sqq) * 60'd110 + ((60'(r_q) * 60'd52000) << 16)
                     + (60'd62 << 32);
        end
    end

    assign w_ms_start = i_cmd.accept && i_poll;

    lpodm_cdiv #(
        .WIDTH   (MSB),
        .DIVISOR (lpodm_pkg::MS_DIVISOR)
    ) u_ms_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ms_start),
        .i_dividend ({1'b0, n_elapsed[EB-1:3]}),
        .o_quotient (w_ms_q),
        .o_busy     (w_ms_busy)
    );

    lpodm_cdiv #(
        .WIDTH   (CDB),
        .DIVISOR (lpodm_pkg::CONC_DIVISOR)
    ) u_conc_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.p5),
        .i_dividend (w_x[59:26]),
        .o_quotient (w_cd_q),
        .o_busy     (w_cd_busy)
    );

    assign w_conc = (w_cd_q > CDB'(lpodm_pkg::CONC_MAX)) ? lpodm_pkg::CONC_MAX
                                                         : w_cd_q[lpodm_pkg::CONC_BITS-1:0];
    assign w_ok   = (r_stat == lpodm_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_stat;
            r_out_ratio  <= w_ok ? r_q : '0;
            r_out_conc   <= w_ok ? w_conc : '0;
            r_out_ms     <= w_ms_q[lpodm_pkg::MS_BITS-1:0];
        end
    end

    assign o_sts.ok       = w_ok;
    assign o_sts.div_last = (r_div_cnt == DCW'(RB - 1));
    assign o_sts.ms_busy  = w_ms_busy;
    assign o_sts.cd_busy  = w_cd_busy;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_low_ratio     = r_out_ratio;
    assign o_concentration = r_out_conc;
    assign o_elapsed_ms    = r_out_ms;

endmodule

>>> hw/rtl/low_pulse_occupancy_dust_meter.sv
// Low pulse occupancy dust meter. Each input beat is one microsecond tick carrying the
// sensor pin level and a poll flag; a tick without a poll does not stall the input and
// gives no result. A poll closes the sample window and gives one result beat with the
// status, the low occupancy ratio, the dust concentration and the elapsed milliseconds.
// A poll that yields a measurement keeps the input stalled through one check, 23 steps
// of the bit-serial ratio divider, a rounding step, five polynomial steps and 17 radix-4
// steps of the divide-by-25 unit. A poll without a measurement keeps the input stalled
// until the radix-4 divide-by-125 unit has formed the milliseconds. A result waits in
// the output register, and the next poll is only held back at its very end if that
// result has not yet been taken. Configuration writes take effect at once and must be
// made only while the block is idle.
module low_pulse_occupancy_dust_meter #(
    parameter int WINDOW_COUNTER_BITS = lpodm_pkg::WINDOW_COUNTER_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_pin_level,
    input  logic                                  i_poll,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [lpodm_pkg::STATUS_BITS-1:0]     o_status,
    output logic [lpodm_pkg::RATIO_BITS-1:0]      o_low_ratio,
    output logic [lpodm_pkg::CONC_BITS-1:0]       o_concentration,
    output logic [lpodm_pkg::MS_BITS-1:0]         o_elapsed_ms,
    input  logic                                  i_cfg_we,
    input  logic [lpodm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lpodm_pkg::CFG_BITS-1:0]        i_cfg_data
);

    lpodm_pkg::t_cmd w_cmd;
    lpodm_pkg::t_sts w_sts;

    lpodm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_poll  (i_poll),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    lpodm_dp #(
        .WINDOW_COUNTER_BITS (WINDOW_COUNTER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_pin_level     (i_pin_level),
        .i_poll          (i_poll),
        .i_stall         (i_stall),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_low_ratio     (o_low_ratio),
        .o_concentration (o_concentration),
        .o_elapsed_ms    (o_elapsed_ms)
    );

endmodule

>>> hw/rtl/lpodm_checker.sv
module lpodm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_poll,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [lpodm_pkg::STATUS_BITS-1:0] i_status,
    input  logic [lpodm_pkg::RATIO_BITS-1:0]  i_ratio,
    input  logic [lpodm_pkg::CONC_BITS-1:0]   i_conc,
    input  logic [lpodm_pkg::MS_BITS-1:0]     i_ms
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_status) && $stable(i_ratio)
            && $stable(i_conc) && $stable(i_ms))
        else $error("result beat changed while stalled");

    a_no_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != lpodm_pkg::ST_OK |-> i_ratio == '0 && i_conc == '0)
        else $error("measurement fields set without an ok status");

    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_ratio <= lpodm_pkg::RATIO_MAX)
        else $error("ratio above one hundred percent");

    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_poll |=> i_in_stall)
        else $error("input not stalled after an accepted poll");

endmodule

bind low_pulse_occupancy_dust_meter lpodm_checker u_lpodm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_poll      (i_poll),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_status    (o_status),
    .i_ratio     (o_low_ratio),
    .i_conc      (o_concentration),
    .i_ms        (o_elapsed_ms)
);

>>> verif/low_pulse_occupancy_dust_meter_test.sv
`timescale 1ns / 1ps

module low_pulse_occupancy_dust_meter_test;

    localparam int WIN_BITS      = lpodm_pkg::WINDOW_COUNTER_BITS_DEF;
    localparam int SETTLE_CYCLES = 64;

    localparam logic [lpodm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [lpodm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [lpodm_pkg::STATUS_BITS-1:0] status;
        logic [lpodm_pkg::RATIO_BITS-1:0]  ratio;
        logic [lpodm_pkg::CONC_BITS-1:0]   conc;
        logic [lpodm_pkg::MS_BITS-1:0]     ms;
    } t_reading;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    logic                                 i_pin_level = 1'b1;
    logic                                 i_poll      = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    logic [lpodm_pkg::STATUS_BITS-1:0]    o_status;
    logic [lpodm_pkg::RATIO_BITS-1:0]     o_low_ratio;
    logic [lpodm_pkg::CONC_BITS-1:0]      o_concentration;
    logic [lpodm_pkg::MS_BITS-1:0]        o_elapsed_ms;
    logic                                 i_cfg_we    = 1'b0;
    logic [lpodm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = lpodm_pkg::REG_WARMUP;
    logic [lpodm_pkg::CFG_BITS-1:0]       i_cfg_data  = '0;

    logic [lpodm_pkg::ELAPSED_BITS-1:0] elapsed_ticks;
    logic [WIN_BITS-1:0]                window_ticks;
    logic [WIN_BITS-1:0]                low_ticks;
    logic [lpodm_pkg::CFG_BITS-1:0]     warmup_limit;
    logic [lpodm_pkg::CFG_BITS-1:0]     min_window;

    t_reading readings_due[$];
    int       errors;
    int       ticks_sent;
    int       polls_sent;
    int       status_count [4] = '{default: 0};
    int       stall_left;
    bit       idling_on;

    always #1 i_clk = ~i_clk;

    low_pulse_occupancy_dust_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pin_level     (i_pin_level),
        .i_poll          (i_poll),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_low_ratio     (o_low_ratio),
        .o_concentration (o_concentration),
        .o_elapsed_ms    (o_elapsed_ms),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    function automatic int pause_length();
        int pick;
        if (!idling_on) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Low occupancy in percent, Q16, rounded half up from an exact long division.
    function automatic logic [63:0] occupancy_ratio(input logic [63:0] low,
                                                    input logic [63:0] win);
        logic [63:0] quo;
        logic [63:0] rem;
        int          i;
        quo = (low * 64'd100) / win;
        rem = (low * 64'd100) % win;
        for (i = 0; i < lpodm_pkg::RATIO_FRAC_BITS; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= win) begin
                rem = rem - win;
                quo = quo | 64'd1;
            end
        end
        if ((rem << 1) >= win) begin
            quo = quo + 64'd1;
        end
        return quo;
    endfunction

    // The cubic is summed at a hundred times its value in Q32 and then scaled to Q8.
    function automatic logic [63:0] dust_density(input logic [63:0] q);
        logic [63:0] sq;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] den;
        logic [63:0] c;
        sq  = (q * q + 64'd32768) >> 16;
        pos = 64'd110 * sq * q + ((64'd52000 * q) << 16) + (64'd62 << 32);
        neg = (64'd380 * sq) << 16;
        den = 64'd100 << 24;
        if (pos <= neg) begin
            return 64'd0;
        end
        c = (pos - neg + (den >> 1)) / den;
        return (c > 64'(lpodm_pkg::CONC_MAX)) ? 64'(lpodm_pkg::CONC_MAX) : c;
    endfunction

    function automatic void advance_meter(input logic pin, input logic poll);
        logic [63:0] win;
        logic [63:0] low;
        logic [63:0] q;
        t_reading    r;
        if (elapsed_ticks != '1) elapsed_ticks = elapsed_ticks + 1'b1;
        if (window_ticks != '1) window_ticks = window_ticks + 1'b1;
        if (!pin && low_ticks != '1) low_ticks = low_ticks + 1'b1;
        if (!poll) begin
            return;
        end
        win          = 64'(window_ticks);
        low          = 64'(low_ticks);
        window_ticks = '0;
        low_ticks    = '0;
        r            = '0;
        r.ms         = lpodm_pkg::MS_BITS'(elapsed_ticks / 1000);
        if (elapsed_ticks < warmup_limit) begin
            r.status = lpodm_pkg::ST_WARMUP;
        end else if (win == 0 || win < 64'(min_window)) begin
            r.status = lpodm_pkg::ST_SHORT;
        end else if (low > win) begin
            r.status = lpodm_pkg::ST_EXCEED;
        end else begin
            q        = occupancy_ratio(low, win);
            r.status = lpodm_pkg::ST_OK;
            r.ratio  = lpodm_pkg::RATIO_BITS'(q);
            r.conc   = lpodm_pkg::CONC_BITS'(dust_density(q));
        end
        readings_due.push_back(r);
        status_count[r.status]++;
    endfunction

    always @(posedge i_clk) begin
        if (stall_left == 0) stall_left = pause_length();
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (readings_due.size() == 0) begin
                $error("result beat arrived with no poll pending");
                errors++;
            end else begin
                want = readings_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_low_ratio !== want.ratio) begin
                    $error("low_ratio: expected %0d, got %0d", want.ratio,
                           o_low_ratio);
                    errors++;
                end
                if (o_concentration !== want.conc) begin
                    $error("concentration: expected %0d, got %0d", want.conc,
                           o_concentration);
                    errors++;
                end
                if (o_elapsed_ms !== want.ms) begin
                    $error("elapsed_ms: expected %0d, got %0d", want.ms,
                           o_elapsed_ms);
                    errors++;
                end
            end
        end
    end

    task automatic send_tick(input logic pin, input logic poll);
        int pause;
        pause = pause_length();
        if (pause > 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pin_level <= pin;
        i_poll      <= poll;
        do @(posedge i_clk); while (o_stall);
        advance_meter(pin, poll);
        ticks_sent++;
        if (poll) polls_sent++;
    endtask

    // A window of len ticks closed by a poll; low_pct is the chance of a low tick.
    task automatic send_window(input int len, input int low_pct);
        int k;
        for (k = 1; k <= len; k++) begin
            send_tick($urandom_range(0, 99) >= low_pct, k == len);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [lpodm_pkg::CFG_BITS-1:0] warm,
                                 input logic [lpodm_pkg::CFG_BITS-1:0] min_win);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lpodm_pkg::REG_WARMUP;
        i_cfg_data  <= warm;
        @(posedge i_clk);
        warmup_limit = warm;
        i_cfg_index <= lpodm_pkg::REG_MIN_WINDOW;
        i_cfg_data  <= min_win;
        @(posedge i_clk);
        min_window = min_win;
        // Writes to the unused indexes must leave both registers alone.
        i_cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_windows(input int budget, input bit with_idling);
        int stop;
        int len;
        int pick;
        stop = ticks_sent + budget;
        while (ticks_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 20);
            end else if (pick < 95) begin
                len = $urandom_range(21, 80);
            end else begin
                len = $urandom_range(150, 300);
            end
            idling_on = with_idling && ($urandom_range(0, 6) != 0);
            pick      = $urandom_range(0, 9);
            send_window(len, (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(0, 100));
        end
    endtask

    task automatic test_warmup_after_reset();
        idling_on = 1'b1;
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_ratio_extremes();
        load_settings('0, '0);
        send_window(1, 100);
        send_window(1, 0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_thresholds();
        load_settings(lpodm_pkg::CFG_BITS'(elapsed_ticks) + 3, '0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        load_settings('0, 5);
        send_window(4, 50);
        send_window(5, 50);
    endtask

    task automatic test_register_extremes();
        load_settings('1, '0);
        send_window(2, 50);
        load_settings('0, '1);
        send_window(2, 50);
    endtask

    task automatic test_random_windows();
        load_settings('0, '0);
        run_windows(200, 1'b0);
        load_settings(lpodm_pkg::CFG_BITS'(elapsed_ticks) + 300, 16);
        run_windows(250, 1'b1);
        load_settings(lpodm_pkg::CFG_BITS'(elapsed_ticks) + $urandom_range(0, 500),
                      $urandom_range(1, 40));
        run_windows(250, 1'b1);
        load_settings('0, '1);
        run_windows(60, 1'b1);
        load_settings('1, $urandom);
        run_windows(60, 1'b1);
        load_settings('0, $urandom_range(0, 8));
        run_windows(200, 1'b1);
        drain_results();
    endtask

    initial begin
        errors        = 0;
        ticks_sent    = 0;
        polls_sent    = 0;
        stall_left    = 0;
        idling_on     = 1'b0;
        elapsed_ticks = '0;
        window_ticks  = '0;
        low_ticks     = '0;
        warmup_limit  = lpodm_pkg::WARMUP_RESET;
        min_window    = lpodm_pkg::MIN_WINDOW_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_warmup_after_reset();
        test_ratio_extremes();
        test_thresholds();
        test_register_extremes();
        test_random_windows();

        $display("Sent %0d ticks with %0d polls across several register settings.",
                 ticks_sent, polls_sent);
        $display("Results: %0d measured, %0d warming up, %0d short windows.",
                 status_count[lpodm_pkg::ST_OK], status_count[lpodm_pkg::ST_WARMUP],
                 status_count[lpodm_pkg::ST_SHORT]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> low_pulse_occupancy_dust_meter.f
hw/rtl/lpodm_pkg.sv
hw/rtl/lpodm_cdiv.sv
hw/rtl/lpodm_ctrl.sv
hw/rtl/lpodm_dp.sv
hw/rtl/low_pulse_occupancy_dust_meter.sv
hw/rtl/lpodm_checker.sv
verif/low_pulse_occupancy_dust_meter_test.sv
